FILE: rtl/core/rkl_pkg.sv
package rkl_pkg;

    localparam int DEF_USER_COUNT  = 5;
    localparam int DEF_CODE_DIGITS = 4;
    localparam int MAX_CODE_DIGITS = 8;

    localparam int KEY_COUNT   = 17;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] KEY_LAST_DIGIT = 5'd9;
    localparam logic [4:0] KEY_STAR       = 5'd10;
    localparam logic [4:0] KEY_HASH       = 5'd11;
    localparam logic [4:0] KEY_A          = 5'd12;
    localparam logic [4:0] KEY_B          = 5'd13;
    localparam logic [4:0] KEY_POWER      = 5'd16;

    // Frame for each key: digits 0 to 9, star, hash, A to D, power.
    localparam logic [31:0] KEY_FRAMES [KEY_COUNT] = '{
        32'h01FEE01F, 32'h01FE50AF, 32'h01FED827, 32'h01FEF807, 32'h01FE30CF,
        32'h01FEB04F, 32'h01FE708F, 32'h01FE00FF, 32'h01FEF00F, 32'h01FE9867,
        32'h01FE58A7, 32'h01FE7887,
        32'h01FE807F, 32'h01FE40BF, 32'h01FEC03F, 32'h01FE20DF,
        32'h01FE48B7
    };

    typedef enum logic [2:0] {
        PH_POWER   = 3'd0,
        PH_WELCOME = 3'd1,
        PH_USER    = 3'd2,
        PH_CODE    = 3'd3,
        PH_MENU    = 3'd4,
        PH_NEWCODE = 3'd5,
        PH_RUN     = 3'd6
    } phase_t;

    typedef enum logic [3:0] {
        EV_IGNORED   = 4'd0,
        EV_ADVANCED  = 4'd1,
        EV_USER      = 4'd2,
        EV_DIGIT     = 4'd3,
        EV_GRANTED   = 4'd4,
        EV_DENIED    = 4'd5,
        EV_CHANGED   = 4'd6,
        EV_CANCELLED = 4'd7,
        EV_ENTERED   = 4'd8
    } event_t;

    typedef struct packed {
        logic       known;
        logic [4:0] key;
    } key_item_t;

    // Reset code: digits 1, 2, 3, ... taken mod 10, first digit in the top nibble of the low 4*digits bits.
    function automatic logic [4*MAX_CODE_DIGITS-1:0] default_code(input int digits);
        logic [4*MAX_CODE_DIGITS-1:0] code;
        code = '0;
        for (int i = 0; i < MAX_CODE_DIGITS; i++)
        begin
            if (i < digits)
            begin
                code = {code[4*MAX_CODE_DIGITS-5:0], 4'((i + 1) % 10)};
            end
        end
        return code;
    endfunction

endpackage

FILE: rtl/core/rkl_if.sv
interface rkl_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] remote_code;

    modport source (output valid, output remote_code, input ready);
    modport sink (input valid, input remote_code, output ready);
endinterface

interface rkl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic [3:0] event_res;
    logic [2:0] user_index;
    logic [2:0] digit_count;
    logic       key_known;

    modport source (output valid, output phase, output event_res, output user_index,
                    output digit_count, output key_known, input ready);
    modport sink (input valid, input phase, input event_res, input user_index,
                  input digit_count, input key_known, output ready);
endinterface

FILE: rtl/core/rkl_front.sv
module rkl_front
    import rkl_pkg::*;
(
    rkl_in_if.sink    frame,
    output key_item_t push_item,
    output logic      push_valid,
    input  logic      push_ready
);

    always_comb
    begin
        push_item.known = 1'b0;
        push_item.key   = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (frame.remote_code == KEY_FRAMES[k])
            begin
                push_item.known = 1'b1;
                push_item.key   = 5'(k);
            end
        end
    end

    assign push_valid  = frame.valid;
    assign frame.ready = push_ready;

endmodule

FILE: rtl/core/rkl_queue.sv
module rkl_queue
    import rkl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  key_item_t push_item,
    input  logic      push_valid,
    output logic      push_ready,
    output key_item_t pop_item,
    output logic      pop_valid,
    input  logic      pop_ready
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    key_item_t         entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/rkl_back.sv
module rkl_back
    import rkl_pkg::*;
#(
    parameter int USER_COUNT  = DEF_USER_COUNT,
    parameter int CODE_DIGITS = DEF_CODE_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  key_item_t pop_item,
    input  logic      pop_valid,
    output logic      pop_ready,
    rkl_out_if.source result
);

    localparam int UW = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
    localparam int DW = $clog2(CODE_DIGITS + 1);
    localparam int CW = 4 * CODE_DIGITS;
    localparam logic [CW-1:0] RESET_CODE = CW'(default_code(CODE_DIGITS));

    phase_t         phase_reg, phase_next;
    logic [UW-1:0]  user_reg, user_next;
    logic           flag_reg, flag_next;
    logic [DW-1:0]  digits_reg, digits_next;
    logic [CW-1:0]  buffer_reg, buffer_next;
    logic [CW-1:0]  store_reg [USER_COUNT];
    logic           store_we;
    logic [UW-1:0]  store_idx;
    event_t         ev;
    logic           fire;
    logic           is_digit;
    logic           out_valid_reg;
    phase_t         out_phase_reg;
    event_t         out_event_reg;
    logic [2:0]     out_user_reg;
    logic [2:0]     out_digits_reg;
    logic           out_known_reg;

    assign pop_ready = !out_valid_reg || result.ready;
    assign fire      = pop_valid && pop_ready;
    assign is_digit  = (pop_item.key <= KEY_LAST_DIGIT);
    assign store_idx = (int'(user_reg) < USER_COUNT) ? user_reg : '0;

    always_comb
    begin
        phase_next  = phase_reg;
        user_next   = user_reg;
        flag_next   = flag_reg;
        digits_next = digits_reg;
        buffer_next = buffer_reg;
        store_we    = 1'b0;
        ev          = EV_IGNORED;
        if (fire && pop_item.known)
        begin
            case (phase_reg)
                PH_POWER:
                begin
                    if (pop_item.key == KEY_POWER)
                    begin
                        phase_next = PH_WELCOME;
                        ev         = EV_ADVANCED;
                    end
                end
                PH_WELCOME:
                begin
                    if (pop_item.key == KEY_STAR)
                    begin
                        phase_next  = PH_USER;
                        user_next   = '0;
                        flag_next   = 1'b0;
                        digits_next = '0;
                        ev          = EV_ADVANCED;
                    end
                end
                PH_USER:
                begin
                    if (is_digit && pop_item.key >= 5'd1 && pop_item.key <= 5'(USER_COUNT))
                    begin
                        user_next = UW'(pop_item.key - 5'd1);
                        flag_next = 1'b1;
                        ev        = EV_USER;
                    end
                    else if (pop_item.key == KEY_HASH && flag_reg)
                    begin
                        phase_next  = PH_CODE;
                        digits_next = '0;
                        ev          = EV_ADVANCED;
                    end
                    else if (pop_item.key == KEY_STAR)
                    begin
                        user_next   = '0;
                        flag_next   = 1'b0;
                        digits_next = '0;
                        ev          = EV_CANCELLED;
                    end
                end
                PH_CODE, PH_NEWCODE:
                begin
                    if (is_digit)
                    begin
                        if (digits_reg < DW'(CODE_DIGITS))
                        begin
                            buffer_next = CW'({buffer_reg, pop_item.key[3:0]});
                            digits_next = digits_reg + 1'b1;
                            ev          = EV_DIGIT;
                        end
                    end
                    else if (pop_item.key == KEY_STAR)
                    begin
                        phase_next  = PH_USER;
                        user_next   = '0;
                        flag_next   = 1'b0;
                        digits_next = '0;
                        ev          = EV_CANCELLED;
                    end
                    else if (pop_item.key == KEY_HASH && digits_reg == DW'(CODE_DIGITS))
                    begin
                        if (phase_reg == PH_CODE && buffer_reg == store_reg[store_idx])
                        begin
                            phase_next  = PH_MENU;
                            digits_next = '0;
                            ev          = EV_GRANTED;
                        end
                        else
                        begin
                            phase_next  = PH_USER;
                            user_next   = '0;
                            flag_next   = 1'b0;
                            digits_next = '0;
                            if (phase_reg == PH_CODE)
                            begin
                                ev = EV_DENIED;
                            end
                            else
                            begin
                                store_we = 1'b1;
                                ev       = EV_CHANGED;
                            end
                        end
                    end
                end
                PH_MENU:
                begin
                    if (pop_item.key == KEY_A)
                    begin
                        phase_next  = PH_NEWCODE;
                        digits_next = '0;
                        ev          = EV_ADVANCED;
                    end
                    else if (pop_item.key == KEY_B)
                    begin
                        phase_next = PH_RUN;
                        ev         = EV_ENTERED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_POWER;
            user_reg      <= '0;
            flag_reg      <= 1'b0;
            digits_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int u = 0; u < USER_COUNT; u++)
            begin
                store_reg[u] <= RESET_CODE;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            user_reg   <= user_next;
            flag_reg   <= flag_next;
            digits_reg <= digits_next;
            if (store_we)
            begin
                store_reg[store_idx] <= buffer_reg;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buffer_reg <= buffer_next;
        if (fire)
        begin
            out_phase_reg  <= phase_next;
            out_event_reg  <= ev;
            out_user_reg   <= flag_next ? 3'(user_next) : 3'd0;
            out_digits_reg <= 3'(digits_next);
            out_known_reg  <= pop_item.known;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.phase       = out_phase_reg;
    assign result.event_res   = out_event_reg;
    assign result.user_index  = out_user_reg;
    assign result.digit_count = out_digits_reg;
    assign result.key_known   = out_known_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg <= DW'(CODE_DIGITS))
        else $error("Digit count exceeds the code length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RUN |=> phase_reg == PH_RUN)
        else $error("The lock left the running phase.");

    assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> int'(user_reg) < USER_COUNT)
        else $error("Selected user is out of range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_POWER || phase_reg == PH_WELCOME) |-> !flag_reg)
        else $error("A user is selected before user select.");

    assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> phase_reg == PH_NEWCODE && flag_reg)
        else $error("Code store written outside new code entry.");

endmodule

FILE: rtl/core/remote_keypad_code_lock.sv
// Code lock driven by raw infrared remote frames. Each item on frame is one 32-bit frame;
// the front end maps it to a key, a two-item queue holds the keys, and the back end runs
// the lock sequence (power, star, user select with hash, four-digit code with hash, then
// a menu with A for a new code or B for the running phase) and writes exactly one result
// item per frame. The block takes one item every cycle while the queue has room. The
// queue registers each key, and the back end's phase update then loads the result
// register, from which the result is taken. Frame accepts continue while the queue has
// room, so a stalled result holds off input only after two more items are queued.
module remote_keypad_code_lock
    import rkl_pkg::*;
#(
    parameter int USER_COUNT  = DEF_USER_COUNT,
    parameter int CODE_DIGITS = DEF_CODE_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    rkl_in_if.sink    frame,
    rkl_out_if.source result
);

    key_item_t push_item;
    logic      push_valid;
    logic      push_ready;
    key_item_t pop_item;
    logic      pop_valid;
    logic      pop_ready;

    rkl_front u_front (
        .frame      (frame),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    rkl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    rkl_back #(
        .USER_COUNT  (USER_COUNT),
        .CODE_DIGITS (CODE_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

FILE: tb/sv/code_lock_checker.sv
module code_lock_checker
    import rkl_pkg::*;
#(
    parameter int USER_COUNT  = DEF_USER_COUNT,
    parameter int CODE_DIGITS = DEF_CODE_DIGITS
)
(
    input  logic clk,
    input  logic rst_n,
    rkl_in_if    frame,
    rkl_out_if   result,
    output int   failures,
    output int   pending
);

    typedef struct {
        phase_t     phase;
        event_t     ev;
        logic [2:0] user;
        logic [2:0] count;
        logic       known;
    } lock_outcome_t;

    phase_t                   cur_phase;
    int                       sel_user;
    logic                     user_picked;
    logic [4*CODE_DIGITS-1:0] entry_digits;
    int                       entry_len;
    logic [4*CODE_DIGITS-1:0] user_codes [USER_COUNT];
    lock_outcome_t            outcomes_q [$];
    lock_outcome_t            want;

    task automatic reset_lock();
        logic [4*CODE_DIGITS-1:0] start_code;
        start_code = '0;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            start_code = {start_code[4*CODE_DIGITS-1:0], 4'((i + 1) % 10)} >> 0;
        end
        for (int u = 0; u < USER_COUNT; u++)
        begin
            user_codes[u] = start_code;
        end
        cur_phase    = PH_POWER;
        sel_user     = 0;
        user_picked  = 1'b0;
        entry_digits = '0;
        entry_len    = 0;
    endtask

    task automatic back_to_user_select();
        cur_phase   = PH_USER;
        sel_user    = 0;
        user_picked = 1'b0;
        entry_len   = 0;
    endtask

    task automatic apply_key_frame(input logic [31:0] frame_code, output lock_outcome_t res);
        logic       known;
        logic [4:0] key;
        logic       is_digit;
        event_t     ev;
        int         u;
        known = 1'b0;
        key   = '0;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (!known && KEY_FRAMES[i] == frame_code)
            begin
                known = 1'b1;
                key   = 5'(i);
            end
        end
        is_digit = known && (key <= KEY_LAST_DIGIT);
        ev = EV_IGNORED;
        if (known)
        begin
            case (cur_phase)
                PH_POWER:
                begin
                    if (key == KEY_POWER)
                    begin
                        cur_phase = PH_WELCOME;
                        ev = EV_ADVANCED;
                    end
                end
                PH_WELCOME:
                begin
                    if (key == KEY_STAR)
                    begin
                        back_to_user_select();
                        ev = EV_ADVANCED;
                    end
                end
                PH_USER:
                begin
                    if (is_digit && key >= 5'd1 && key <= USER_COUNT)
                    begin
                        sel_user    = int'(key) - 1;
                        user_picked = 1'b1;
                        ev = EV_USER;
                    end
                    else if (key == KEY_HASH && user_picked)
                    begin
                        cur_phase = PH_CODE;
                        entry_len = 0;
                        ev = EV_ADVANCED;
                    end
                    else if (key == KEY_STAR)
                    begin
                        back_to_user_select();
                        ev = EV_CANCELLED;
                    end
                end
                PH_CODE, PH_NEWCODE:
                begin
                    if (is_digit)
                    begin
                        if (entry_len < CODE_DIGITS)
                        begin
                            entry_digits = (entry_digits << 4) | key[3:0];
                            entry_len++;
                            ev = EV_DIGIT;
                        end
                    end
                    else if (key == KEY_STAR)
                    begin
                        back_to_user_select();
                        ev = EV_CANCELLED;
                    end
                    else if (key == KEY_HASH && entry_len == CODE_DIGITS)
                    begin
                        u = (sel_user < USER_COUNT) ? sel_user : 0;
                        if (cur_phase == PH_CODE)
                        begin
                            if (entry_digits == user_codes[u])
                            begin
                                cur_phase = PH_MENU;
                                entry_len = 0;
                                ev = EV_GRANTED;
                            end
                            else
                            begin
                                back_to_user_select();
                                ev = EV_DENIED;
                            end
                        end
                        else
                        begin
                            user_codes[u] = entry_digits;
                            back_to_user_select();
                            ev = EV_CHANGED;
                        end
                    end
                end
                PH_MENU:
                begin
                    if (key == KEY_A)
                    begin
                        cur_phase = PH_NEWCODE;
                        entry_len = 0;
                        ev = EV_ADVANCED;
                    end
                    else if (key == KEY_B)
                    begin
                        cur_phase = PH_RUN;
                        ev = EV_ENTERED;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.phase = cur_phase;
        res.ev    = ev;
        res.user  = user_picked ? 3'(sel_user) : 3'd0;
        res.count = 3'(entry_len);
        res.known = known;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_lock();
            outcomes_q.delete();
            failures = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (outcomes_q.size() == 0)
                begin
                    $error("result item arrived with no item pending");
                    failures++;
                end
                else
                begin
                    want = outcomes_q.pop_front();
                    if (result.phase !== want.phase)
                    begin
                        $error("phase: expected %0d, actual %0d", want.phase, result.phase);
                        failures++;
                    end
                    if (result.event_res !== want.ev)
                    begin
                        $error("event_res: expected %0d, actual %0d", want.ev, result.event_res);
                        failures++;
                    end
                    if (result.user_index !== want.user)
                    begin
                        $error("user_index: expected %0d, actual %0d",
                               want.user, result.user_index);
                        failures++;
                    end
                    if (result.digit_count !== want.count)
                    begin
                        $error("digit_count: expected %0d, actual %0d",
                               want.count, result.digit_count);
                        failures++;
                    end
                    if (result.key_known !== want.known)
                    begin
                        $error("key_known: expected %0d, actual %0d",
                               want.known, result.key_known);
                        failures++;
                    end
                end
            end
            if (frame.valid && frame.ready)
            begin
                apply_key_frame(frame.remote_code, want);
                outcomes_q.push_back(want);
            end
        end
        pending = outcomes_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import rkl_pkg::*;

    localparam int         USERS          = DEF_USER_COUNT;
    localparam int         DIGITS         = DEF_CODE_DIGITS;
    localparam int         CODE_W         = 4 * DEF_CODE_DIGITS;
    localparam int         RANDOM_ITEMS   = 700;
    localparam logic [4:0] KEY_C          = 5'd14;
    localparam logic [4:0] KEY_D          = 5'd15;
    localparam int         DIRECTED_COUNT = 27;

    localparam logic [31:0] DIRECTED_FRAMES [DIRECTED_COUNT] = '{
        32'h0000_0000, 32'hFFFF_FFFF,
        KEY_FRAMES[KEY_STAR], KEY_FRAMES[KEY_B], KEY_FRAMES[KEY_POWER],
        KEY_FRAMES[KEY_HASH], KEY_FRAMES[KEY_STAR],
        KEY_FRAMES[0], KEY_FRAMES[6], KEY_FRAMES[KEY_HASH],
        KEY_FRAMES[5], KEY_FRAMES[KEY_STAR], KEY_FRAMES[1], KEY_FRAMES[KEY_HASH],
        KEY_FRAMES[1], KEY_FRAMES[2], KEY_FRAMES[KEY_HASH], KEY_FRAMES[3],
        KEY_FRAMES[4], KEY_FRAMES[9], KEY_FRAMES[KEY_HASH],
        KEY_FRAMES[KEY_C], KEY_FRAMES[KEY_A],
        KEY_FRAMES[9], KEY_FRAMES[0], KEY_FRAMES[KEY_STAR], KEY_FRAMES[KEY_D]
    };

    logic              clk;
    logic              rst_n;
    int                failures;
    int                pending;
    int                items_sent = 0;
    int                sender_idle_pct = 0;
    int                stall_pct = 0;
    logic [CODE_W-1:0] believed_codes [USERS];

    rkl_in_if  frame_if ();
    rkl_out_if result_if ();

    remote_keypad_code_lock dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .result (result_if)
    );

    code_lock_checker lock_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame_if),
        .result   (result_if),
        .failures (failures),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct = 53;
                stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct = 53;
            end
            default:
            begin
                sender_idle_pct = 12;
                stall_pct = 12;
            end
        endcase
    endtask

    task automatic send_frame(input logic [31:0] code);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            frame_if.valid <= 1'b0;
            @(posedge clk);
        end
        frame_if.valid       <= 1'b1;
        frame_if.remote_code <= code;
        do
            @(posedge clk);
        while (!frame_if.ready);
        items_sent++;
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] code;
        code = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            code = (code << 4) | 4'($urandom_range(0, 9));
        end
        return code;
    endfunction

    task automatic stray_items(input int pct, input bit any_key);
        logic [4:0] k;
        while ($urandom_range(0, 99) < pct)
        begin
            case ($urandom_range(0, any_key ? 3 : 2))
                0: send_frame($urandom());
                1: send_frame(KEY_FRAMES[$urandom_range(0, KEY_COUNT - 1)]
                              ^ (32'h1 << $urandom_range(0, 31)));
                2: send_frame($urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF);
                default:
                begin
                    k = 5'($urandom_range(0, KEY_COUNT - 1));
                    if (k == KEY_B)
                    begin
                        k = KEY_D;
                    end
                    send_frame(KEY_FRAMES[k]);
                end
            endcase
        end
    endtask

    task automatic enter_code(input logic [CODE_W-1:0] code, output bit completed);
        int cut;
        cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, DIGITS - 1) : -1;
        completed = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (i == cut)
            begin
                send_frame(KEY_FRAMES[KEY_STAR]);
                completed = 1'b0;
                return;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                send_frame(KEY_FRAMES[KEY_HASH]);
            end
            stray_items(10, 1'b0);
            send_frame(KEY_FRAMES[code[CODE_W-1-4*i -: 4]]);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            send_frame(KEY_FRAMES[$urandom_range(0, 9)]);
        end
    endtask

    // Power, A and star bring the lock to user select from any phase short of running.
    task automatic lock_session();
        int                u;
        logic [CODE_W-1:0] attempt;
        bit                completed;
        send_frame(KEY_FRAMES[KEY_POWER]);
        send_frame(KEY_FRAMES[KEY_A]);
        send_frame(KEY_FRAMES[KEY_STAR]);
        if ($urandom_range(0, 9) == 0)
        begin
            send_frame(KEY_FRAMES[KEY_HASH]);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            send_frame(KEY_FRAMES[$urandom_range(0, 1) ? 0 : $urandom_range(USERS + 1, 9)]);
        end
        u = $urandom_range(1, USERS);
        if ($urandom_range(0, 7) == 0)
        begin
            send_frame(KEY_FRAMES[$urandom_range(1, USERS)]);
            send_frame(KEY_FRAMES[KEY_STAR]);
        end
        send_frame(KEY_FRAMES[u]);
        stray_items(15, 1'b0);
        send_frame(KEY_FRAMES[KEY_HASH]);
        attempt = ($urandom_range(0, 99) < 70) ? believed_codes[u-1] : random_code();
        enter_code(attempt, completed);
        if (!completed)
        begin
            return;
        end
        send_frame(KEY_FRAMES[KEY_HASH]);
        if (attempt != believed_codes[u-1])
        begin
            return;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            send_frame(KEY_FRAMES[KEY_A]);
            attempt = random_code();
            enter_code(attempt, completed);
            if (completed)
            begin
                send_frame(KEY_FRAMES[KEY_HASH]);
                believed_codes[u-1] = attempt;
            end
        end
        else
        begin
            stray_items(50, 1'b1);
        end
    endtask

    initial
    begin
        frame_if.valid       <= 1'b0;
        frame_if.remote_code <= '0;
        rst_n                <= 1'b0;
        for (int u = 0; u < USERS; u++)
        begin
            believed_codes[u] = CODE_W'(default_code(DIGITS));
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_frame(DIRECTED_FRAMES[i]);
        end

        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            set_idling((items_sent - DIRECTED_COUNT) * 4 / RANDOM_ITEMS);
            lock_session();
        end
        set_idling(0);

        // Finish in the running phase, where every key is ignored.
        send_frame(KEY_FRAMES[KEY_POWER]);
        send_frame(KEY_FRAMES[KEY_A]);
        send_frame(KEY_FRAMES[KEY_STAR]);
        send_frame(KEY_FRAMES[1]);
        send_frame(KEY_FRAMES[KEY_HASH]);
        for (int i = 0; i < DIGITS; i++)
        begin
            send_frame(KEY_FRAMES[believed_codes[0][CODE_W-1-4*i -: 4]]);
        end
        send_frame(KEY_FRAMES[KEY_HASH]);
        send_frame(KEY_FRAMES[KEY_B]);
        send_frame(KEY_FRAMES[KEY_POWER]);
        send_frame(KEY_FRAMES[KEY_STAR]);
        send_frame(KEY_FRAMES[2]);
        send_frame(KEY_FRAMES[KEY_HASH]);
        send_frame(KEY_FRAMES[KEY_A]);
        frame_if.valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
